// ----- sv/bdi_pkg.sv -----
package bdi_pkg;

    localparam int LINE_BYTES  = 64;
    localparam int NUM_OPTIONS = 8;
    localparam int LINE_WORDS  = LINE_BYTES / 8;
    localparam int IDX_W       = (LINE_WORDS > 1) ? $clog2(LINE_WORDS) : 1;
    localparam int WORD_W      = 64;
    localparam int SIZE_W      = 7;
    localparam int OPT_W       = 4;
    localparam int NUM_REPEAT  = 4;
    localparam int NUM_DELTA   = 6;
    // Wide enough to hold every candidate size, the line size included.
    localparam int BEST_W      = $clog2(LINE_BYTES + 1);

    localparam logic [OPT_W-1:0] OPT_ZERO         = 4'd0;
    localparam logic [OPT_W-1:0] OPT_REPEAT       = 4'd1;
    localparam logic [OPT_W-1:0] OPT_DELTA_FIRST  = 4'd2;
    localparam logic [OPT_W-1:0] OPT_UNCOMPRESSED = 4'(NUM_OPTIONS);

    typedef int delta_tab_t [NUM_DELTA];

    localparam delta_tab_t DELTA_BASE_BYTES = '{8, 8, 8, 4, 4, 2};
    localparam delta_tab_t DELTA_BYTES      = '{1, 2, 4, 1, 2, 1};

    // Number of base-sized elements in one 64-bit word.
    localparam delta_tab_t DELTA_ELEMS = '{
        8 / DELTA_BASE_BYTES[0], 8 / DELTA_BASE_BYTES[1], 8 / DELTA_BASE_BYTES[2],
        8 / DELTA_BASE_BYTES[3], 8 / DELTA_BASE_BYTES[4], 8 / DELTA_BASE_BYTES[5]
    };

    // Encoded size of each base-delta option.
    localparam delta_tab_t DELTA_SIZES = '{
        DELTA_BASE_BYTES[0] + (LINE_BYTES / DELTA_BASE_BYTES[0]) * DELTA_BYTES[0],
        DELTA_BASE_BYTES[1] + (LINE_BYTES / DELTA_BASE_BYTES[1]) * DELTA_BYTES[1],
        DELTA_BASE_BYTES[2] + (LINE_BYTES / DELTA_BASE_BYTES[2]) * DELTA_BYTES[2],
        DELTA_BASE_BYTES[3] + (LINE_BYTES / DELTA_BASE_BYTES[3]) * DELTA_BYTES[3],
        DELTA_BASE_BYTES[4] + (LINE_BYTES / DELTA_BASE_BYTES[4]) * DELTA_BYTES[4],
        DELTA_BASE_BYTES[5] + (LINE_BYTES / DELTA_BASE_BYTES[5]) * DELTA_BYTES[5]
    };

    typedef struct packed {
        logic                  zero_ok;
        logic [NUM_REPEAT-1:0] rep_ok;
        logic [NUM_DELTA-1:0]  delta_ok;
    } bdi_check_t;

endpackage

// ----- sv/bdi_in_if.sv -----
interface bdi_in_if;
    import bdi_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] line_word;

    modport source (output valid, output line_word, input ready);
    modport sink   (input valid, input line_word, output ready);
endinterface

// ----- sv/bdi_out_if.sv -----
interface bdi_out_if;
    import bdi_pkg::*;

    logic              valid;
    logic              ready;
    logic [SIZE_W-1:0] packed_size;
    logic [OPT_W-1:0]  option_code;

    modport source (output valid, output packed_size, output option_code, input ready);
    modport sink   (input valid, input packed_size, input option_code, output ready);
endinterface

// ----- sv/bdi_check.sv -----
module bdi_check (
    input  logic [bdi_pkg::WORD_W-1:0] word,
    input  logic [bdi_pkg::WORD_W-1:0] base,
    output bdi_pkg::bdi_check_t        check
);
    import bdi_pkg::*;

    // Low 8*bb bits of v, sign-extended to 65 bits.
    function automatic logic [64:0] sext(logic [63:0] v, int bb);
        logic [64:0] raw;
        logic [64:0] sgn;
        raw = {1'b0, v} & ((65'd1 << (8 * bb)) - 65'd1);
        sgn = 65'd1 << (8 * bb - 1);
        return (raw ^ sgn) - sgn;
    endfunction

    // Low 2^i bytes of b repeated across the word.
    function automatic logic [63:0] replicate(logic [63:0] b, int i);
        logic [63:0] r;
        int          k;
        int          j;
        k = 1 << i;
        r = '0;
        for (j = 0; j < 8; j++) begin
            if (j < (8 >> i)) begin
                r = r | ((b & ((64'd1 << (8 * k)) - 64'd1)) << (8 * k * j));
            end
        end
        if (k == 8) begin
            r = b;
        end
        return r;
    endfunction

    // Every element of the word minus the first base element fits the signed delta.
    function automatic logic delta_word_ok(logic [63:0] w, logic [63:0] b, int bb, int db,
                                           int per);
        logic        ok;
        logic [64:0] be;
        logic [64:0] el;
        logic [64:0] diff;
        logic [63:0] wrap;
        logic [64:0] bias;
        int          j;
        ok   = 1'b1;
        be   = sext(b, bb);
        bias = 65'd1 << (8 * db - 1);
        for (j = 0; j < 8; j++) begin
            if (j < per) begin
                el = sext(w >> (8 * bb * j), bb);
                if (bb == 8) begin
                    // Full-width deltas wrap at 64 bits.
                    wrap = w - b;
                    diff = {wrap[63], wrap};
                end
                else begin
                    diff = el - be;
                end
                if (((diff + bias) >> (8 * db)) != 65'd0) begin
                    ok = 1'b0;
                end
            end
        end
        return ok;
    endfunction

    always_comb
    begin
        check.zero_ok = (word == '0);
        for (int i = 0; i < NUM_REPEAT; i++) begin
            check.rep_ok[i] = (word == replicate(base, i));
        end
        for (int i = 0; i < NUM_DELTA; i++) begin
            check.delta_ok[i] = delta_word_ok(word, base, DELTA_BASE_BYTES[i],
                                              DELTA_BYTES[i], DELTA_ELEMS[i]);
        end
    end

endmodule

// ----- sv/bdi_line_size_estimator_unit.sv -----
// Channel   Dir  Payload                          Word
// line      in   line_word[63:0]                  8 bytes of a line, byte 0 in bits 7:0
// estimate  out  packed_size[6:0], option_code    one per line, after its last word
//
// One line word is taken per cycle while the input is not stalled; a line's last
// word passes the input register, then the output register, which presents its estimate.
// The input register feeds the word checks and the option select, which end in
// the running flags and the output register.
// Reset clears the word count, the pipeline valids and the output valid.
// The input side stalls only while a finished line's last word waits for a full
// output register that is not being emptied.
module bdi_line_size_estimator_unit (
    input logic clk,
    input logic rst_n,
    bdi_in_if.sink    line,
    bdi_out_if.source estimate
);
    import bdi_pkg::*;

    logic [IDX_W-1:0]      idx_reg;
    logic [IDX_W-1:0]      idx_next;
    logic                  s1_valid_reg;
    logic                  s1_first_reg;
    logic                  s1_last_reg;
    logic [WORD_W-1:0]     s1_word_reg;
    logic [WORD_W-1:0]     base_reg;
    bdi_check_t            flags_reg;
    bdi_check_t            flags_next;
    bdi_check_t            word_check;
    logic                  out_valid_reg;
    logic [SIZE_W-1:0]     size_reg;
    logic [OPT_W-1:0]      opt_reg;
    logic [WORD_W-1:0]     base_sel;
    logic                  in_acc;
    logic                  out_free;
    logic                  s1_adv;
    logic [BEST_W-1:0]     best;
    logic [OPT_W-1:0]      opt;
    logic                  rep_found;

    assign in_acc   = line.valid && line.ready;
    assign out_free = !out_valid_reg || estimate.ready;
    assign s1_adv   = s1_valid_reg && (!s1_last_reg || out_free);
    assign line.ready = !s1_valid_reg || s1_adv;

    assign idx_next = (idx_reg == IDX_W'(LINE_WORDS - 1)) ? '0 : idx_reg + 1'b1;
    assign base_sel = s1_first_reg ? s1_word_reg : base_reg;

    bdi_check u_check (
        .word  (s1_word_reg),
        .base  (base_sel),
        .check (word_check)
    );

    // The first word of a line restarts every flag.
    assign flags_next = (s1_first_reg ? '1 : flags_reg) & word_check;

    always_comb
    begin
        best      = BEST_W'(LINE_BYTES);
        opt       = OPT_UNCOMPRESSED;
        rep_found = 1'b0;
        if (flags_next.zero_ok && (BEST_W'(1) < best)) begin
            best = BEST_W'(1);
            opt  = OPT_ZERO;
        end
        for (int i = 0; i < NUM_REPEAT; i++) begin
            if (flags_next.rep_ok[i] && !rep_found) begin
                rep_found = 1'b1;
                if (BEST_W'(1 << i) < best) begin
                    best = BEST_W'(1 << i);
                    opt  = OPT_REPEAT;
                end
            end
        end
        for (int i = 0; i < NUM_DELTA; i++) begin
            if (flags_next.delta_ok[i] && (BEST_W'(DELTA_SIZES[i]) < best)) begin
                best = BEST_W'(DELTA_SIZES[i]);
                opt  = OPT_DELTA_FIRST + OPT_W'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else begin
            if (in_acc) begin
                idx_reg <= idx_next;
            end
            if (in_acc) begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv && s1_last_reg) begin
                out_valid_reg <= 1'b1;
            end
            else if (estimate.ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc) begin
            s1_word_reg  <= line.line_word;
            s1_first_reg <= (idx_reg == '0);
            s1_last_reg  <= (idx_reg == IDX_W'(LINE_WORDS - 1));
        end
        if (s1_adv) begin
            flags_reg <= flags_next;
            if (s1_first_reg) begin
                base_reg <= s1_word_reg;
            end
        end
        if (s1_adv && s1_last_reg) begin
            size_reg <= best[SIZE_W-1:0];
            opt_reg  <= opt;
        end
    end

    assign estimate.valid       = out_valid_reg;
    assign estimate.packed_size = size_reg;
    assign estimate.option_code = opt_reg;

`ifndef SYNTHESIS
    a_stall_from_output: assert property (@(posedge clk) disable iff (!rst_n)
        !line.ready |-> (estimate.valid && !estimate.ready))
        else $error("input stalled without a blocked output word");

    a_result_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_adv && s1_last_reg))
        else $error("estimate produced without a line end");

    a_uncompressed_size: assert property (@(posedge clk) disable iff (!rst_n)
        (estimate.valid && estimate.option_code == OPT_UNCOMPRESSED)
        |-> (estimate.packed_size == SIZE_W'(LINE_BYTES)))
        else $error("uncompressed estimate with a size other than the line size");

    a_zero_size: assert property (@(posedge clk) disable iff (!rst_n)
        (estimate.valid && estimate.option_code == OPT_ZERO)
        |-> (estimate.packed_size == SIZE_W'(1)))
        else $error("zero line estimate with a size other than one byte");
`endif

endmodule

// ----- bench/bdi_estimate_checker.sv -----
module bdi_estimate_checker
    import bdi_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    bdi_in_if                    line_mon,
    bdi_out_if                   est_mon,
    output int                   fail_count,
    output int                   pending,
    output int                   lines_checked,
    output int                   words_taken,
    output logic [NUM_OPTIONS:0] options_seen
);

    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic [OPT_W-1:0]  option;
    } estimate_t;

    logic [WORD_W-1:0]     line_base;
    int                    word_count;
    logic                  all_zero;
    logic [NUM_REPEAT-1:0] repeat_flags;
    logic [NUM_DELTA-1:0]  delta_flags;
    estimate_t             expected_q [$];

    task automatic clear_line();
        line_base    = '0;
        word_count   = 0;
        all_zero     = 1'b1;
        repeat_flags = '1;
        delta_flags  = '1;
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("[%0t] mismatch: %s, got %0d, expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    // Element j of nbytes bytes within w, sign-extended to the full word.
    function automatic logic [WORD_W-1:0] signed_element(logic [WORD_W-1:0] w,
                                                         int nbytes, int j);
        logic signed [WORD_W-1:0] t;
        int                       bits;
        bits = 8 * nbytes;
        if (nbytes >= 8)
            return w;
        t = w >> (bits * j);
        t = t << (WORD_W - bits);
        t = t >>> (WORD_W - bits);
        return t;
    endfunction

    task automatic absorb_word(logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] base_elem, diff, bias;
        logic [OPT_W-1:0]  option;
        int                bb, db, best, sz;
        logic              found;
        estimate_t         est;
        if (word_count == 0)
            line_base = w;
        if (w != '0)
            all_zero = 1'b0;
        if (w != {8{line_base[7:0]}})
            repeat_flags[0] = 1'b0;
        if (w != {4{line_base[15:0]}})
            repeat_flags[1] = 1'b0;
        if (w != {2{line_base[31:0]}})
            repeat_flags[2] = 1'b0;
        if (w != line_base)
            repeat_flags[3] = 1'b0;
        for (int i = 0; i < NUM_DELTA; i++)
        begin
            bb        = DELTA_BASE_BYTES[i];
            db        = DELTA_BYTES[i];
            base_elem = signed_element(line_base, bb, 0);
            bias      = 64'd1 << (8 * db - 1);
            for (int j = 0; j < 8 / bb; j++)
            begin
                // The difference wraps at 64 bits and is then range-checked as signed.
                diff = signed_element(w, bb, j) - base_elem;
                if ((diff + bias) >= (64'd1 << (8 * db)))
                    delta_flags[i] = 1'b0;
            end
        end
        word_count++;
        if (word_count < LINE_WORDS)
            return;

        best   = LINE_BYTES;
        option = OPT_UNCOMPRESSED;
        if (all_zero && best > 1)
        begin
            best   = 1;
            option = OPT_ZERO;
        end
        found = 1'b0;
        for (int i = 0; i < NUM_REPEAT; i++)
        begin
            if (!found && repeat_flags[i])
            begin
                found = 1'b1;
                if ((1 << i) < best)
                begin
                    best   = 1 << i;
                    option = OPT_REPEAT;
                end
            end
        end
        // Strict comparison keeps the earlier option when sizes tie.
        for (int i = 0; i < NUM_DELTA; i++)
        begin
            bb = DELTA_BASE_BYTES[i];
            sz = bb + (LINE_BYTES / bb) * DELTA_BYTES[i];
            if (delta_flags[i] && sz < best)
            begin
                best   = sz;
                option = OPT_DELTA_FIRST + OPT_W'(i);
            end
        end
        est.size   = SIZE_W'(best);
        est.option = option;
        expected_q = {expected_q, est};
        clear_line();
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        estimate_t want;
        if (!rst_n)
        begin
            clear_line();
            expected_q.delete();
            fail_count    = 0;
            pending       = 0;
            lines_checked = 0;
            words_taken   = 0;
            options_seen  = '0;
        end
        else
        begin
            // Results are checked before this edge's input word is absorbed.
            if (est_mon.valid && est_mon.ready)
            begin
                if (expected_q.size() == 0)
                    report_mismatch("estimate with no line pending", est_mon.packed_size, 0);
                else
                begin
                    want = expected_q.pop_front();
                    if (est_mon.packed_size !== want.size)
                        report_mismatch("packed_size", est_mon.packed_size, want.size);
                    if (est_mon.option_code !== want.option)
                        report_mismatch("option_code", est_mon.option_code, want.option);
                    options_seen[want.option] = 1'b1;
                    lines_checked++;
                end
            end
            if (line_mon.valid && line_mon.ready)
            begin
                absorb_word(line_mon.line_word);
                words_taken++;
            end
            pending = expected_q.size();
        end
    end

endmodule

// ----- bench/tb_bdi_line_size_estimator_unit.sv -----
module tb_bdi_line_size_estimator_unit;
    import bdi_pkg::*;

    localparam int RANDOM_LINES = 72;
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 150;

    typedef enum int {LINE_ZERO, LINE_REPEAT, LINE_DELTA, LINE_NOISE} line_kind_e;

    logic                 clk;
    logic                 rst_n;
    int                   send_idle;
    int                   recv_idle;
    logic                 hold_req;
    int                   quiet_cycles = 0;
    logic [WORD_W-1:0]    line_buf [LINE_WORDS];
    int                   fail_count;
    int                   pending;
    int                   lines_checked;
    int                   words_taken;
    logic [NUM_OPTIONS:0] options_seen;

    bdi_in_if  line_ch ();
    bdi_out_if est_ch ();

    bdi_line_size_estimator_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .line     (line_ch),
        .estimate (est_ch)
    );

    bdi_estimate_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .line_mon      (line_ch),
        .est_mon       (est_ch),
        .fail_count    (fail_count),
        .pending       (pending),
        .lines_checked (lines_checked),
        .words_taken   (words_taken),
        .options_seen  (options_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [WORD_W-1:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    // Called at a falling edge; returns at the falling edge after the last word is taken.
    task automatic send_line();
        for (int n = 0; n < LINE_WORDS; n++)
        begin
            while ($urandom_range(99) < send_idle)
            begin
                line_ch.valid <= 1'b0;
                @(negedge clk);
            end
            line_ch.valid     <= 1'b1;
            line_ch.line_word <= line_buf[n];
            @(posedge clk);
            while (!line_ch.ready)
                @(posedge clk);
            @(negedge clk);
        end
    endtask

    task automatic make_line(line_kind_e kind, logic broken);
        logic [WORD_W-1:0]        pat, base, el, mask;
        logic signed [WORD_W-1:0] lim, d;
        int                       opt_i, bb, db, per, bad;
        foreach (line_buf[i])
            line_buf[i] = '0;
        case (kind)
            LINE_ZERO:
                ;
            LINE_REPEAT:
            begin
                pat = rand_word();
                case ($urandom_range(3))
                    0: pat = {8{pat[7:0]}};
                    1: pat = {4{pat[15:0]}};
                    2: pat = {2{pat[31:0]}};
                    default: ;
                endcase
                foreach (line_buf[i])
                    line_buf[i] = pat;
            end
            LINE_DELTA:
            begin
                opt_i = $urandom_range(NUM_DELTA - 1);
                bb    = DELTA_BASE_BYTES[opt_i];
                db    = DELTA_BYTES[opt_i];
                per   = 8 / bb;
                mask  = (bb == 8) ? '1 : ((64'd1 << (8 * bb)) - 1);
                lim   = 64'sd1 << (8 * db - 1);
                base  = rand_word();
                bad   = $urandom_range(LINE_WORDS * per - 1, 1);
                // Half the deltas sit at the edges of their range; a broken line has one
                // element just outside it.
                for (int n = 0; n < LINE_WORDS * per; n++)
                begin
                    case ($urandom_range(3))
                        0: d = lim - 1;
                        1: d = -lim;
                        default:
                        begin
                            d = rand_word();
                            d = d << (WORD_W - 8 * db);
                            d = d >>> (WORD_W - 8 * db);
                        end
                    endcase
                    if (n == 0)
                        d = 0;
                    if (broken && n == bad)
                        d = $urandom_range(1) ? lim : -lim - 1;
                    el = (base + d) & mask;
                    line_buf[n / per] |= el << (8 * bb * (n % per));
                end
            end
            default:
                foreach (line_buf[i])
                    line_buf[i] = rand_word();
        endcase
        if (broken && (kind == LINE_ZERO || kind == LINE_REPEAT))
            line_buf[$urandom_range(LINE_WORDS - 1)][$urandom_range(WORD_W - 1)] ^= 1'b1;
    endtask

    initial
    begin : receiver
        int   hold_left;
        logic hold_used;
        hold_left = 0;
        hold_used = 1'b0;
        est_ch.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            // The long hold is taken once, when the stimulus first asks for it.
            if (hold_req && !hold_used)
            begin
                hold_left = HOLD_CYCLES;
                hold_used = 1'b1;
            end
            if (hold_left > 0)
            begin
                est_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                est_ch.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (line_ch.valid && line_ch.ready) || (est_ch.valid && est_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("No word moved on either channel for %0d cycles.", STALL_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : stimulus
        int         r;
        line_kind_e kind;
        rst_n              = 1'b0;
        hold_req           = 1'b0;
        send_idle          = 33;
        recv_idle          = 80;
        line_ch.valid     <= 1'b0;
        line_ch.line_word <= '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // All-zero line, all-ones line, then a line whose 64-bit deltas wrap.
        foreach (line_buf[i])
            line_buf[i] = '0;
        send_line();
        foreach (line_buf[i])
            line_buf[i] = '1;
        send_line();
        foreach (line_buf[i])
            line_buf[i] = (i % 2 == 1) ? 64'h7FFF_FFFF_FFFF_FFFF : 64'h8000_0000_0000_0000;
        send_line();

        for (int p = 0; p < 3; p++)
        begin
            if (p == 1)
            begin
                send_idle = 80;
                recv_idle = 33;
            end
            if (p == 2)
            begin
                send_idle = 0;
                recv_idle = 0;
                hold_req  = 1'b1;
            end
            repeat (RANDOM_LINES / 3)
            begin
                r = $urandom_range(99);
                if (r < 10)
                    kind = LINE_ZERO;
                else if (r < 30)
                    kind = LINE_REPEAT;
                else if (r < 80)
                    kind = LINE_DELTA;
                else
                    kind = LINE_NOISE;
                make_line(kind, $urandom_range(3) == 0);
                send_line();
            end
        end
        line_ch.valid <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);

        $display("Covered %0d lines (%0d words) over three handshake mixes and a long output hold.",
                 lines_checked, words_taken);
        $display("Options reported, one bit per option from 8 down to 0: %b", options_seen);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- bdi_line_size_estimator_unit.f -----
sv/bdi_pkg.sv
sv/bdi_in_if.sv
sv/bdi_out_if.sv
sv/bdi_check.sv
sv/bdi_line_size_estimator_unit.sv
bench/bdi_estimate_checker.sv
bench/tb_bdi_line_size_estimator_unit.sv
